// ----- hdl/ppmw_pkg.sv -----
// Package for the pointer port memory window.
// Holds shared constants, register codes and the controller/datapath interface types.
// Depends on nothing.
`default_nettype none

package ppmw_pkg;

    localparam int RAM_ADDR_BITS_DEF = 21;
    localparam int PORT_COUNT_DEF    = 4;

    localparam int DATA_W = 8;
    localparam int BASE_W = 24;
    localparam int OFS_W  = 16;
    localparam int CTL_W  = 7;

    // Selects the shift and identification group.
    localparam logic [2:0] GROUP_SEL = 3'd4;

    // Pointer port register codes.
    localparam logic [3:0] PREG_DATA0   = 4'd0;
    localparam logic [3:0] PREG_DATA1   = 4'd1;
    localparam logic [3:0] PREG_BASE0   = 4'd2;
    localparam logic [3:0] PREG_BASE1   = 4'd3;
    localparam logic [3:0] PREG_BASE2   = 4'd4;
    localparam logic [3:0] PREG_OFS_LO  = 4'd5;
    localparam logic [3:0] PREG_OFS_HI  = 4'd6;
    localparam logic [3:0] PREG_INC_LO  = 4'd7;
    localparam logic [3:0] PREG_INC_HI  = 4'd8;
    localparam logic [3:0] PREG_CONTROL = 4'd9;
    localparam logic [3:0] PREG_ADJUST  = 4'd10;

    // Group register codes.
    localparam logic [3:0] GREG_SHIFT0  = 4'd0;
    localparam logic [3:0] GREG_SHIFT1  = 4'd1;
    localparam logic [3:0] GREG_SHIFT2  = 4'd2;
    localparam logic [3:0] GREG_SHIFT3  = 4'd3;
    localparam logic [3:0] GREG_COUNT   = 4'd4;
    localparam logic [3:0] GREG_HOLD    = 4'd5;
    localparam logic [3:0] GREG_ZERO    = 4'd13;
    localparam logic [3:0] GREG_VERSION = 4'd14;
    localparam logic [3:0] GREG_ID      = 4'd15;

    // Control bit positions.
    localparam int CTL_INC_EN   = 0;
    localparam int CTL_USE_OFS  = 1;
    localparam int CTL_EXT      = 3;
    localparam int CTL_INC_BASE = 4;
    localparam int CTL_ADD_HI   = 5;
    localparam int CTL_ADD_ADJ  = 6;

    localparam logic [BASE_W-1:0] EXT_ADD     = 24'hFF0000;
    localparam logic [DATA_W-1:0] VERSION_VAL = 8'h10;
    localparam logic [DATA_W-1:0] ID_VAL      = 8'h51;
    localparam logic [DATA_W-1:0] UNMAPPED    = 8'hFF;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RAM_WAIT
    } state_t;

    typedef struct packed {
        logic capture;   // latch the item on the input ports
        logic execute;   // perform the register work and issue the RAM access
        logic ram_take;  // return the registered RAM read data
    } cmd_t;

    typedef struct packed {
        logic ram_read;  // the held item is a data read on a valid port
    } status_t;

endpackage

`default_nettype wire

// ----- hdl/ppmw_ram.sv -----
// Generic single-port RAM with a registered read.
// Depends on nothing.
`default_nettype none

module ppmw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/ppmw_ctrl.sv -----
// Controller state machine of the pointer port memory window.
// Depends on ppmw_pkg.
`default_nettype none

module ppmw_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire ppmw_pkg::status_t  status,
    output logic                    busy,
    output ppmw_pkg::cmd_t          cmd
);

    ppmw_pkg::state_t state_reg;
    ppmw_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ppmw_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ppmw_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ppmw_pkg::ST_EXEC;
                end
            end
            ppmw_pkg::ST_EXEC:
            begin
                if (status.ram_read)
                begin
                    state_next = ppmw_pkg::ST_RAM_WAIT;
                end
                else
                begin
                    state_next = ppmw_pkg::ST_IDLE;
                end
            end
            ppmw_pkg::ST_RAM_WAIT:
            begin
                state_next = ppmw_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = ppmw_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy         = 1'b1;
        cmd.capture  = 1'b0;
        cmd.execute  = 1'b0;
        cmd.ram_take = 1'b0;
        case (state_reg)
            ppmw_pkg::ST_IDLE:
            begin
                busy        = 1'b0;
                cmd.capture = start;
            end
            ppmw_pkg::ST_EXEC:
            begin
                cmd.execute = 1'b1;
            end
            ppmw_pkg::ST_RAM_WAIT:
            begin
                cmd.ram_take = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/ppmw_datapath.sv -----
// Datapath of the pointer port memory window: item latch, port and group
// registers, address adder, RAM and result register.
// Depends on ppmw_pkg and ppmw_ram.
`default_nettype none

module ppmw_datapath #(
    parameter int RAM_ADDR_BITS = ppmw_pkg::RAM_ADDR_BITS_DEF,
    parameter int PORT_COUNT    = ppmw_pkg::PORT_COUNT_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire ppmw_pkg::cmd_t                cmd,
    input  wire logic                          opcode,
    input  wire logic [2:0]                    port_select,
    input  wire logic [3:0]                    reg_index,
    input  wire logic [ppmw_pkg::DATA_W-1:0]   write_data,
    output ppmw_pkg::status_t                  status,
    output logic [ppmw_pkg::DATA_W-1:0]        read_data,
    output logic                               done
);

    localparam int PIDX_W   = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
    localparam int RAM_DEPTH = 2 ** RAM_ADDR_BITS;
    localparam int BW = ppmw_pkg::BASE_W;
    localparam int OW = ppmw_pkg::OFS_W;
    localparam int CW = ppmw_pkg::CTL_W;
    localparam int DW = ppmw_pkg::DATA_W;

    // Held item.
    logic          op_reg;
    logic [2:0]    psel_reg;
    logic [3:0]    ridx_reg;
    logic [DW-1:0] wdata_reg;

    // Port registers and group registers.
    logic [BW-1:0] base_reg [PORT_COUNT];
    logic [BW-1:0] base_next [PORT_COUNT];
    logic [OW-1:0] ofs_reg  [PORT_COUNT];
    logic [OW-1:0] ofs_next [PORT_COUNT];
    logic [OW-1:0] inc_reg  [PORT_COUNT];
    logic [OW-1:0] inc_next [PORT_COUNT];
    logic [CW-1:0] ctl_reg  [PORT_COUNT];
    logic [CW-1:0] ctl_next [PORT_COUNT];
    logic [31:0]   shift_reg;
    logic [31:0]   shift_next;
    logic [3:0]    count_reg;
    logic [3:0]    count_next;
    logic [DW-1:0] hold_reg;
    logic [DW-1:0] hold_next;

    logic [DW-1:0] result_reg;
    logic [DW-1:0] result_next;
    logic          done_reg;
    logic          done_next;

    logic [PIDX_W-1:0] p;
    logic              port_ok;
    logic              group_ok;
    logic              is_data;
    logic [BW-1:0]     cur_base;
    logic [OW-1:0]     cur_ofs;
    logic [OW-1:0]     cur_inc;
    logic [CW-1:0]     cur_ctl;
    logic [BW-1:0]     ext_term;
    logic [BW-1:0]     ofs_sum;
    logic [BW-1:0]     ram_addr_full;
    logic [OW-1:0]     ofs_hi_new;
    logic [DW-1:0]     port_rd;
    logic [DW-1:0]     group_rd;
    logic [DW-1:0]     rd_value;
    logic [4:0]        rshift;
    logic [3:0]        sh_n;
    logic              ram_en;
    logic              ram_we;
    logic [DW-1:0]     ram_rdata;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= opcode;
            psel_reg  <= port_select;
            ridx_reg  <= reg_index;
            wdata_reg <= write_data;
        end
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PORT_COUNT; i++)
            begin
                base_reg[i] <= '0;
                ofs_reg[i]  <= '0;
                inc_reg[i]  <= '0;
                ctl_reg[i]  <= '0;
            end
            shift_reg <= '0;
            count_reg <= '0;
            hold_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            base_reg  <= base_next;
            ofs_reg   <= ofs_next;
            inc_reg   <= inc_next;
            ctl_reg   <= ctl_next;
            shift_reg <= shift_next;
            count_reg <= count_next;
            hold_reg  <= hold_next;
            done_reg  <= done_next;
        end
    end

    assign p        = psel_reg[PIDX_W-1:0];
    assign port_ok  = (psel_reg < 3'(PORT_COUNT));
    assign group_ok = (psel_reg == ppmw_pkg::GROUP_SEL);
    assign is_data  = (ridx_reg == ppmw_pkg::PREG_DATA0) || (ridx_reg == ppmw_pkg::PREG_DATA1);

    assign cur_base = base_reg[p];
    assign cur_ofs  = ofs_reg[p];
    assign cur_inc  = inc_reg[p];
    assign cur_ctl  = ctl_reg[p];

    // Base plus offset, with the extend term; shared by data and adjust.
    assign ext_term = cur_ctl[ppmw_pkg::CTL_EXT] ? ppmw_pkg::EXT_ADD : '0;
    assign ofs_sum  = cur_base + BW'(cur_ofs) + ext_term;
    assign ram_addr_full = cur_ctl[ppmw_pkg::CTL_USE_OFS] ? ofs_sum : cur_base;
    assign ofs_hi_new    = {wdata_reg, cur_ofs[7:0]};

    assign sh_n   = wdata_reg[3:0];
    assign rshift = 5'd16 - {1'b0, sh_n};

    assign ram_en = cmd.execute && port_ok && is_data;
    assign ram_we = ram_en && op_reg;
    assign status.ram_read = port_ok && is_data && !op_reg;

    ppmw_ram #(
        .WIDTH (DW),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr_full[RAM_ADDR_BITS-1:0]),
        .wdata (wdata_reg),
        .rdata (ram_rdata)
    );

    // Read values.
    always_comb
    begin
        case (ridx_reg)
            ppmw_pkg::PREG_DATA0,
            ppmw_pkg::PREG_DATA1:   port_rd = '0;
            ppmw_pkg::PREG_BASE0:   port_rd = cur_base[7:0];
            ppmw_pkg::PREG_BASE1:   port_rd = cur_base[15:8];
            ppmw_pkg::PREG_BASE2:   port_rd = cur_base[23:16];
            ppmw_pkg::PREG_OFS_LO:  port_rd = cur_ofs[7:0];
            ppmw_pkg::PREG_OFS_HI:  port_rd = cur_ofs[15:8];
            ppmw_pkg::PREG_INC_LO:  port_rd = cur_inc[7:0];
            ppmw_pkg::PREG_INC_HI:  port_rd = cur_inc[15:8];
            ppmw_pkg::PREG_CONTROL: port_rd = {1'b0, cur_ctl};
            ppmw_pkg::PREG_ADJUST:  port_rd = '0;
            default:                port_rd = ppmw_pkg::UNMAPPED;
        endcase

        case (ridx_reg)
            ppmw_pkg::GREG_SHIFT0:  group_rd = shift_reg[7:0];
            ppmw_pkg::GREG_SHIFT1:  group_rd = shift_reg[15:8];
            ppmw_pkg::GREG_SHIFT2:  group_rd = shift_reg[23:16];
            ppmw_pkg::GREG_SHIFT3:  group_rd = shift_reg[31:24];
            ppmw_pkg::GREG_COUNT:   group_rd = {4'b0, count_reg};
            ppmw_pkg::GREG_HOLD:    group_rd = hold_reg;
            ppmw_pkg::GREG_ZERO:    group_rd = '0;
            ppmw_pkg::GREG_VERSION: group_rd = ppmw_pkg::VERSION_VAL;
            ppmw_pkg::GREG_ID:      group_rd = ppmw_pkg::ID_VAL;
            default:                group_rd = ppmw_pkg::UNMAPPED;
        endcase

        if (op_reg)
        begin
            rd_value = '0;
        end
        else if (port_ok)
        begin
            rd_value = port_rd;
        end
        else if (group_ok)
        begin
            rd_value = group_rd;
        end
        else
        begin
            rd_value = ppmw_pkg::UNMAPPED;
        end
    end

    // Register updates and result.
    always_comb
    begin
        base_next   = base_reg;
        ofs_next    = ofs_reg;
        inc_next    = inc_reg;
        ctl_next    = ctl_reg;
        shift_next  = shift_reg;
        count_next  = count_reg;
        hold_next   = hold_reg;
        result_next = result_reg;
        done_next   = 1'b0;

        if (cmd.ram_take)
        begin
            result_next = ram_rdata;
            done_next   = 1'b1;
        end

        if (cmd.execute)
        begin
            if (!status.ram_read)
            begin
                result_next = rd_value;
                done_next   = 1'b1;
            end

            if (port_ok)
            begin
                if (is_data)
                begin
                    // Auto-increment, when enabled, after every data access, read or write.
                    if (cur_ctl[ppmw_pkg::CTL_INC_EN])
                    begin
                        if (cur_ctl[ppmw_pkg::CTL_INC_BASE])
                        begin
                            base_next[p] = cur_base + BW'(cur_inc);
                        end
                        else
                        begin
                            ofs_next[p] = cur_ofs + cur_inc;
                        end
                    end
                end
                else if (op_reg)
                begin
                    case (ridx_reg)
                        ppmw_pkg::PREG_BASE0:   base_next[p][7:0]   = wdata_reg;
                        ppmw_pkg::PREG_BASE1:   base_next[p][15:8]  = wdata_reg;
                        ppmw_pkg::PREG_BASE2:   base_next[p][23:16] = wdata_reg;
                        ppmw_pkg::PREG_OFS_LO:  ofs_next[p][7:0]    = wdata_reg;
                        ppmw_pkg::PREG_OFS_HI:
                        begin
                            ofs_next[p] = ofs_hi_new;
                            if (cur_ctl[ppmw_pkg::CTL_ADD_HI] && !cur_ctl[ppmw_pkg::CTL_ADD_ADJ])
                            begin
                                base_next[p] = cur_base + BW'(ofs_hi_new);
                            end
                        end
                        ppmw_pkg::PREG_INC_LO:  inc_next[p][7:0]    = wdata_reg;
                        ppmw_pkg::PREG_INC_HI:  inc_next[p][15:8]   = wdata_reg;
                        ppmw_pkg::PREG_CONTROL: ctl_next[p]         = wdata_reg[CW-1:0];
                        ppmw_pkg::PREG_ADJUST:
                        begin
                            if (cur_ctl[ppmw_pkg::CTL_ADD_HI] && cur_ctl[ppmw_pkg::CTL_ADD_ADJ])
                            begin
                                base_next[p] = ofs_sum;
                            end
                        end
                        default:
                        begin
                            base_next = base_reg;
                        end
                    endcase
                end
            end
            else if (group_ok && op_reg)
            begin
                case (ridx_reg)
                    ppmw_pkg::GREG_SHIFT0: shift_next[7:0]   = wdata_reg;
                    ppmw_pkg::GREG_SHIFT1: shift_next[15:8]  = wdata_reg;
                    ppmw_pkg::GREG_SHIFT2: shift_next[23:16] = wdata_reg;
                    ppmw_pkg::GREG_SHIFT3: shift_next[31:24] = wdata_reg;
                    ppmw_pkg::GREG_COUNT:
                    begin
                        // Counts 8 to 15 shift right by sixteen minus the count.
                        if (sh_n[3])
                        begin
                            shift_next = shift_reg >> rshift;
                        end
                        else
                        begin
                            shift_next = shift_reg << sh_n;
                        end
                        count_next = sh_n;
                    end
                    ppmw_pkg::GREG_HOLD:   hold_next = wdata_reg;
                    default:
                    begin
                        hold_next = hold_reg;
                    end
                endcase
            end
        end
    end

    assign read_data = result_reg;
    assign done      = done_reg;

endmodule

`default_nettype wire

// ----- hdl/pointer_port_memory_window.sv -----
// Top level of the pointer port memory window.
// Depends on ppmw_pkg, ppmw_ctrl, ppmw_datapath and ppmw_ram.
`default_nettype none

// Usage
// The block serves byte-wide bus accesses. An item (opcode, port_select,
// reg_index, write_data) is accepted at a rising edge where start is high
// and busy is low. Each item yields exactly one result byte on read_data,
// shown for one cycle with done high; the receiver takes it at the end of
// that cycle and cannot hold it off. Writes always return zero.
// A register access shows its result once the controller has left its
// execute state, and ends there; a data access that reads the RAM also
// passes the RAM wait state because the RAM read data is registered. The
// next item may be accepted in the very cycle its predecessor's result is
// shown, but not before, so the block does not take a new item while one
// is in flight. The pace is set by the single execute state of the
// controller plus the registered read port of the RAM.
// Reset (rst_n low, asynchronous) clears the port registers, the shift
// word, count and hold register and returns the controller to idle. The RAM is not
// cleared; a read of a never-written byte returns an undefined value.
// A RAM of 2^RAM_ADDR_BITS bytes sits behind the ports; PORT_COUNT sets how
// many pointer ports exist; other non-group selects read unmapped (0xFF).

module pointer_port_memory_window #(
    parameter int RAM_ADDR_BITS = ppmw_pkg::RAM_ADDR_BITS_DEF,
    parameter int PORT_COUNT    = ppmw_pkg::PORT_COUNT_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        opcode,
    input  wire logic [2:0]                  port_select,
    input  wire logic [3:0]                  reg_index,
    input  wire logic [ppmw_pkg::DATA_W-1:0] write_data,
    output logic [ppmw_pkg::DATA_W-1:0]      read_data,
    output logic                             done
);

    ppmw_pkg::cmd_t    cmd;
    ppmw_pkg::status_t status;

    // The controller sequences each item: capture, execute, and an extra
    // wait for the registered RAM data on data reads.
    ppmw_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    // The datapath holds the item, the registers and the RAM, and produces the result strobe.
    ppmw_datapath #(
        .RAM_ADDR_BITS (RAM_ADDR_BITS),
        .PORT_COUNT    (PORT_COUNT)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .opcode      (opcode),
        .port_select (port_select),
        .reg_index   (reg_index),
        .write_data  (write_data),
        .status      (status),
        .read_data   (read_data),
        .done        (done)
    );

endmodule

`default_nettype wire

// ----- hdl/ppmw_checker.sv -----
// Port-level checker for the pointer port memory window, bound to the top level.
// Depends on pointer_port_memory_window.
`default_nettype none

module ppmw_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done
);

    // An accepted item makes the block busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("block not busy after accepting an item");

    // A result strobe lasts one cycle only.
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe longer than one cycle");

    // Results are shown only while the block is free for a new item.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result shown while busy");

    // Finishing an item always delivers its result.
    assert property (@(posedge clk) disable iff (!rst_n) $fell(busy) |-> done)
        else $error("item finished without a result");

    // No result appears right after an item is taken.
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> !done)
        else $error("result in the cycle after acceptance");

endmodule

bind pointer_port_memory_window ppmw_checker u_ppmw_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);

`default_nettype wire

// ----- tb/tb_pointer_port_memory_window.sv -----
// Self-checking testbench for the pointer port memory window.
// Predicts every read byte from its own copy of the port, shift and RAM state.
// Depends on ppmw_pkg and pointer_port_memory_window.
`default_nettype none

module tb_pointer_port_memory_window;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RAM_BITS    = ppmw_pkg::RAM_ADDR_BITS_DEF;
    localparam int PORTS       = ppmw_pkg::PORT_COUNT_DEF;
    localparam int ITEM_TARGET = 1330;
    localparam int QUIET_ITEMS = 150;
    localparam int CYCLE_LIMIT = 100000;

    // Bus access direction.
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    logic                            clk         = 1'b0;
    logic                            rst_n       = 1'b0;
    logic                            start       = 1'b0;
    logic                            opcode      = 1'b0;
    logic [2:0]                      port_select = 3'd0;
    logic [3:0]                      reg_index   = 4'd0;
    logic [ppmw_pkg::DATA_W-1:0]     write_data  = '0;
    logic                            busy;
    logic [ppmw_pkg::DATA_W-1:0]     read_data;
    logic                            done;

    // Our own view of the block: pointer ports, shift group and the RAM
    // bytes written so far. Only written RAM bytes are ever read back.
    logic [ppmw_pkg::BASE_W-1:0]     ptr_base   [0:3];
    logic [ppmw_pkg::OFS_W-1:0]      ptr_offset [0:3];
    logic [ppmw_pkg::OFS_W-1:0]      ptr_step   [0:3];
    logic [ppmw_pkg::CTL_W-1:0]      ptr_ctl    [0:3];
    logic [31:0]                     shift_acc;
    logic [3:0]                      shift_amt;
    logic [7:0]                      hold_byte;
    logic [7:0]                      ram_image  [int unsigned];

    logic [ppmw_pkg::DATA_W-1:0]     expected_bytes [$];
    logic [ppmw_pkg::DATA_W-1:0]     want;
    int                              items_sent = 0;
    int                              errors     = 0;
    int                              cycle_count = 0;
    bit                              gaps_on    = 1'b1;

    pointer_port_memory_window u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .opcode      (opcode),
        .port_select (port_select),
        .reg_index   (reg_index),
        .write_data  (write_data),
        .read_data   (read_data),
        .done        (done)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The run is bounded; a hung handshake or a lost result ends here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL pointer_port_memory_window");
            $finish;
        end
    end

    // RAM address of a data access on port p: the base, or base plus offset
    // with the optional extend constant, wrapped to the RAM size.
    function automatic logic [RAM_BITS-1:0] data_addr(int p);
        logic [ppmw_pkg::BASE_W-1:0] sum;
        sum = ptr_base[p];
        if (ptr_ctl[p][ppmw_pkg::CTL_USE_OFS])
        begin
            sum = sum + ppmw_pkg::BASE_W'(ptr_offset[p]);
            if (ptr_ctl[p][ppmw_pkg::CTL_EXT])
                sum = sum + ppmw_pkg::EXT_ADD;
        end
        return sum[RAM_BITS-1:0];
    endfunction

    // Applies one accepted bus access to our state and returns the byte the
    // block must answer with. Writes always answer zero.
    function automatic logic [ppmw_pkg::DATA_W-1:0] window_access(logic op, logic [2:0] ps,
                                                                  logic [3:0] ri,
                                                                  logic [7:0] wd);
        logic [ppmw_pkg::DATA_W-1:0] rd;
        logic [ppmw_pkg::CTL_W-1:0]  c;
        logic [RAM_BITS-1:0]         a;
        int                          p;
        int                          n;
        rd = '0;
        if (int'(ps) < PORTS)
        begin
            p = int'(ps);
            c = ptr_ctl[p];
            case (ri)
                ppmw_pkg::PREG_DATA0, ppmw_pkg::PREG_DATA1:
                begin
                    a = data_addr(p);
                    if (op == OP_WRITE)
                        ram_image[a] = wd;
                    else if (ram_image.exists(a))
                        rd = ram_image[a];
                    // The auto-increment lands on either the base or the offset.
                    if (c[ppmw_pkg::CTL_INC_EN])
                    begin
                        if (c[ppmw_pkg::CTL_INC_BASE])
                            ptr_base[p] = ptr_base[p] + ppmw_pkg::BASE_W'(ptr_step[p]);
                        else
                            ptr_offset[p] = ptr_offset[p] + ptr_step[p];
                    end
                end
                ppmw_pkg::PREG_BASE0, ppmw_pkg::PREG_BASE1, ppmw_pkg::PREG_BASE2:
                begin
                    if (op == OP_WRITE)
                        ptr_base[p][8*(int'(ri)-2) +: 8] = wd;
                    else
                        rd = ptr_base[p][8*(int'(ri)-2) +: 8];
                end
                ppmw_pkg::PREG_OFS_LO:
                begin
                    if (op == OP_WRITE)
                        ptr_offset[p][7:0] = wd;
                    else
                        rd = ptr_offset[p][7:0];
                end
                ppmw_pkg::PREG_OFS_HI:
                begin
                    if (op == OP_WRITE)
                    begin
                        ptr_offset[p][15:8] = wd;
                        // The new offset is folded into the base on this trigger.
                        if (c[ppmw_pkg::CTL_ADD_HI] && !c[ppmw_pkg::CTL_ADD_ADJ])
                            ptr_base[p] = ptr_base[p] + ppmw_pkg::BASE_W'(ptr_offset[p]);
                    end
                    else
                        rd = ptr_offset[p][15:8];
                end
                ppmw_pkg::PREG_INC_LO:
                begin
                    if (op == OP_WRITE)
                        ptr_step[p][7:0] = wd;
                    else
                        rd = ptr_step[p][7:0];
                end
                ppmw_pkg::PREG_INC_HI:
                begin
                    if (op == OP_WRITE)
                        ptr_step[p][15:8] = wd;
                    else
                        rd = ptr_step[p][15:8];
                end
                ppmw_pkg::PREG_CONTROL:
                begin
                    if (op == OP_WRITE)
                        ptr_ctl[p] = wd[ppmw_pkg::CTL_W-1:0];
                    else
                        rd = {1'b0, c};
                end
                ppmw_pkg::PREG_ADJUST:
                begin
                    // Adjust reads as zero; a write adds only with both triggers set.
                    if (op == OP_WRITE && c[ppmw_pkg::CTL_ADD_HI] && c[ppmw_pkg::CTL_ADD_ADJ])
                    begin
                        ptr_base[p] = ptr_base[p] + ppmw_pkg::BASE_W'(ptr_offset[p]);
                        if (c[ppmw_pkg::CTL_EXT])
                            ptr_base[p] = ptr_base[p] + ppmw_pkg::EXT_ADD;
                    end
                end
                default:
                    rd = ppmw_pkg::UNMAPPED;
            endcase
        end
        else if (ps == ppmw_pkg::GROUP_SEL)
        begin
            case (ri)
                ppmw_pkg::GREG_SHIFT0, ppmw_pkg::GREG_SHIFT1,
                ppmw_pkg::GREG_SHIFT2, ppmw_pkg::GREG_SHIFT3:
                begin
                    if (op == OP_WRITE)
                        shift_acc[8*int'(ri) +: 8] = wd;
                    else
                        rd = shift_acc[8*int'(ri) +: 8];
                end
                ppmw_pkg::GREG_COUNT:
                begin
                    if (op == OP_WRITE)
                    begin
                        // Counts 8 to 15 mean a right shift by 16 minus the count.
                        n = int'(wd[3:0]);
                        if (n > 7)
                            shift_acc = shift_acc >> (16 - n);
                        else
                            shift_acc = shift_acc << n;
                        shift_amt = wd[3:0];
                    end
                    else
                        rd = {4'h0, shift_amt};
                end
                ppmw_pkg::GREG_HOLD:
                begin
                    if (op == OP_WRITE)
                        hold_byte = wd;
                    else
                        rd = hold_byte;
                end
                ppmw_pkg::GREG_ZERO:    rd = '0;
                ppmw_pkg::GREG_VERSION: rd = ppmw_pkg::VERSION_VAL;
                ppmw_pkg::GREG_ID:      rd = ppmw_pkg::ID_VAL;
                default:                rd = ppmw_pkg::UNMAPPED;
            endcase
        end
        else
            rd = ppmw_pkg::UNMAPPED;
        if (op == OP_WRITE)
            rd = '0;
        return rd;
    endfunction

    // Sends one item and records what it must answer. A data read of a RAM
    // byte that was never written turns into a write of the same byte, so
    // the block is never asked for undefined contents.
    task automatic issue_access(input logic op, input logic [2:0] ps,
                                input logic [3:0] ri, input logic [7:0] wd);
        logic op_used;
        int   gap;
        op_used = op;
        if (op == OP_READ && int'(ps) < PORTS &&
            (ri == ppmw_pkg::PREG_DATA0 || ri == ppmw_pkg::PREG_DATA1))
        begin
            if (!ram_image.exists(data_addr(int'(ps))))
                op_used = OP_WRITE;
        end
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 3);
            repeat (gap)
            begin
                @(negedge clk);
                start       = 1'b0;
                opcode      = 1'($urandom);
                port_select = 3'($urandom);
                reg_index   = 4'($urandom);
                write_data  = 8'($urandom);
            end
        end
        @(negedge clk);
        start       = 1'b1;
        opcode      = op_used;
        port_select = ps;
        reg_index   = ri;
        write_data  = wd;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        expected_bytes.push_back(window_access(op_used, ps, ri, wd));
        items_sent++;
    endtask

    // Every done cycle carries exactly one result; it must match the oldest
    // byte still expected.
    always @(posedge clk)
    begin
        if (rst_n && done !== 1'b0)
        begin
            if (expected_bytes.size() == 0)
            begin
                $display("%0t: result with nothing expected: expected none, actual %02h",
                         $time, read_data);
                errors++;
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (done !== 1'b1 || read_data !== want)
                begin
                    $display("%0t: read_data mismatch: expected %02h, actual %02h (done %b)",
                             $time, want, read_data, done);
                    errors++;
                end
            end
        end
    end

    // Data writes walk forward through the RAM on port 0 and are read back
    // after the offset is rewound; the control write keeps only seven bits.
    task automatic test_pointer_data();
        issue_access(OP_WRITE, 3'd0, ppmw_pkg::PREG_CONTROL, 8'hFF);
        issue_access(OP_WRITE, 3'd0, ppmw_pkg::PREG_CONTROL, 8'h03);
        issue_access(OP_WRITE, 3'd0, ppmw_pkg::PREG_INC_LO, 8'h01);
        issue_access(OP_WRITE, 3'd0, ppmw_pkg::PREG_DATA0, 8'hA5);
        issue_access(OP_WRITE, 3'd0, ppmw_pkg::PREG_DATA1, 8'h5A);
        issue_access(OP_WRITE, 3'd0, ppmw_pkg::PREG_OFS_LO, 8'h00);
        issue_access(OP_READ, 3'd0, ppmw_pkg::PREG_DATA0, 8'h00);
        issue_access(OP_READ, 3'd0, ppmw_pkg::PREG_DATA1, 8'hFF);
    endtask

    // Offset-high add, then an extended adjust add that wraps the base.
    task automatic test_add_triggers();
        issue_access(OP_WRITE, 3'd3, ppmw_pkg::PREG_OFS_HI, 8'h80);
        issue_access(OP_WRITE, 3'd3, ppmw_pkg::PREG_CONTROL, 8'h20);
        issue_access(OP_WRITE, 3'd3, ppmw_pkg::PREG_OFS_HI, 8'hFF);
        issue_access(OP_WRITE, 3'd3, ppmw_pkg::PREG_CONTROL, 8'h68);
        issue_access(OP_WRITE, 3'd3, ppmw_pkg::PREG_ADJUST, 8'h00);
        issue_access(OP_READ, 3'd3, ppmw_pkg::PREG_ADJUST, 8'h00);
    endtask

    // Right shift by one (count 15), then left by seven, then the fixed values.
    task automatic test_shift_group();
        issue_access(OP_WRITE, ppmw_pkg::GROUP_SEL, ppmw_pkg::GREG_SHIFT3, 8'h80);
        issue_access(OP_WRITE, ppmw_pkg::GROUP_SEL, ppmw_pkg::GREG_SHIFT0, 8'h81);
        issue_access(OP_WRITE, ppmw_pkg::GROUP_SEL, ppmw_pkg::GREG_COUNT, 8'hFF);
        issue_access(OP_WRITE, ppmw_pkg::GROUP_SEL, ppmw_pkg::GREG_COUNT, 8'h07);
        issue_access(OP_READ, ppmw_pkg::GROUP_SEL, ppmw_pkg::GREG_SHIFT1, 8'h00);
        issue_access(OP_READ, ppmw_pkg::GROUP_SEL, ppmw_pkg::GREG_VERSION, 8'h00);
        issue_access(OP_READ, ppmw_pkg::GROUP_SEL, ppmw_pkg::GREG_ID, 8'h00);
        issue_access(OP_READ, ppmw_pkg::GROUP_SEL, ppmw_pkg::GREG_ZERO, 8'h00);
    endtask

    // Unmapped selects and registers read as all ones and ignore writes.
    task automatic test_unmapped();
        issue_access(OP_READ, 3'd7, 4'd0, 8'h00);
        issue_access(OP_WRITE, 3'd5, 4'd0, 8'hFF);
        issue_access(OP_READ, 3'd2, 4'd15, 8'h00);
        issue_access(OP_READ, ppmw_pkg::GROUP_SEL, 4'd6, 8'h00);
    endtask

    function automatic logic [15:0] pick_word16();
        case ($urandom_range(0, 3))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(1, 4));
            default: return 16'($urandom);
        endcase
    endfunction

    // Programs a port with a random pointer, writes a run of bytes, maybe
    // fires an add trigger, then restores the pointer and reads the run back.
    task automatic port_walk();
        int                p;
        int                n;
        logic [23:0]       base;
        logic [15:0]       ofs;
        logic [15:0]       step;
        logic [7:0]        ctl_byte;
        logic [3:0]        data_reg;
        p        = $urandom_range(0, 3);
        n        = $urandom_range(1, 8);
        base     = ($urandom_range(0, 3) == 0) ? 24'hFFFFFF - 24'($urandom_range(0, 8))
                                               : 24'($urandom);
        ofs      = pick_word16();
        step     = pick_word16();
        ctl_byte = 8'($urandom);
        issue_access(OP_WRITE, 3'(p), ppmw_pkg::PREG_INC_LO, step[7:0]);
        issue_access(OP_WRITE, 3'(p), ppmw_pkg::PREG_INC_HI, step[15:8]);
        // The rewind below repeats these writes; control is cleared first so
        // that the offset-high write cannot move the base.
        for (int pass = 0; pass < 2; pass++)
        begin
            issue_access(OP_WRITE, 3'(p), ppmw_pkg::PREG_CONTROL, 8'h00);
            issue_access(OP_WRITE, 3'(p), ppmw_pkg::PREG_BASE0, base[7:0]);
            issue_access(OP_WRITE, 3'(p), ppmw_pkg::PREG_BASE1, base[15:8]);
            issue_access(OP_WRITE, 3'(p), ppmw_pkg::PREG_BASE2, base[23:16]);
            issue_access(OP_WRITE, 3'(p), ppmw_pkg::PREG_OFS_LO, ofs[7:0]);
            issue_access(OP_WRITE, 3'(p), ppmw_pkg::PREG_OFS_HI, ofs[15:8]);
            issue_access(OP_WRITE, 3'(p), ppmw_pkg::PREG_CONTROL, ctl_byte);
            repeat (n)
            begin
                data_reg = $urandom_range(0, 1) ? ppmw_pkg::PREG_DATA1 : ppmw_pkg::PREG_DATA0;
                issue_access(pass == 0 ? OP_WRITE : OP_READ, 3'(p), data_reg, 8'($urandom));
            end
            if (pass == 0 && $urandom_range(0, 2) == 0)
                issue_access(OP_WRITE, 3'(p),
                             $urandom_range(0, 1) ? ppmw_pkg::PREG_ADJUST : ppmw_pkg::PREG_OFS_HI,
                             8'($urandom));
            if ($urandom_range(0, 1) == 0)
                issue_access(OP_READ, 3'(p), 4'($urandom_range(2, 10)), 8'($urandom));
        end
    endtask

    // Loads the shift word, shifts it by a random count and reads it back.
    task automatic shift_walk();
        for (int b = 0; b < 4; b++)
            issue_access(OP_WRITE, ppmw_pkg::GROUP_SEL, 4'(b), 8'($urandom));
        issue_access(OP_WRITE, ppmw_pkg::GROUP_SEL, ppmw_pkg::GREG_COUNT, 8'($urandom));
        for (int b = 0; b < 4; b++)
            issue_access(OP_READ, ppmw_pkg::GROUP_SEL, 4'(b), 8'($urandom));
        issue_access(OP_READ, ppmw_pkg::GROUP_SEL, ppmw_pkg::GREG_COUNT, 8'($urandom));
        issue_access(OP_WRITE, ppmw_pkg::GROUP_SEL, ppmw_pkg::GREG_HOLD, 8'($urandom));
        issue_access(OP_READ, ppmw_pkg::GROUP_SEL, ppmw_pkg::GREG_HOLD, 8'($urandom));
    endtask

    // Mostly well-formed port and shift sequences, with fully random items
    // as noise. Idling stops for the last stretch of the run.
    task automatic test_random_traffic();
        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent > ITEM_TARGET - QUIET_ITEMS)
                gaps_on = 1'b0;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: port_walk();
                5:             shift_walk();
                default:
                begin
                    repeat ($urandom_range(1, 6))
                        issue_access(1'($urandom), 3'($urandom), 4'($urandom), 8'($urandom));
                end
            endcase
        end
    endtask

    initial
    begin
        for (int p = 0; p < 4; p++)
        begin
            ptr_base[p]   = '0;
            ptr_offset[p] = '0;
            ptr_step[p]   = '0;
            ptr_ctl[p]    = '0;
        end
        shift_acc = '0;
        shift_amt = '0;
        hold_byte = '0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_pointer_data();
        test_add_triggers();
        test_shift_group();
        test_unmapped();
        test_random_traffic();

        @(negedge clk);
        start = 1'b0;

        // Drain: wait for every expected byte, then a few cycles more so that
        // a stray extra result would still be caught.
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (errors == 0)
            $display("PASS pointer_port_memory_window");
        else
            $display("FAIL pointer_port_memory_window");
        $finish;
    end

endmodule

`default_nettype wire
